[rtl/battery_discharge_feature_extractor_core_defines.svh]
// Assertion macros shared by the feature extractor RTL.
`ifndef BATTERY_DISCHARGE_FEATURE_EXTRACTOR_CORE_DEFINES_SVH
`define BATTERY_DISCHARGE_FEATURE_EXTRACTOR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define BDFE_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bdfe assertion failed");
// next-cycle implication
`define BDFE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bdfe assertion failed");
`else
`define BDFE_ASSERT_IMPL(label, clk, rst, ante, cons)
`define BDFE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/bdfe_pkg.sv]
// Package: types and constants of the discharge feature extractor.
`timescale 1ns / 1ps
package bdfe_pkg;

   localparam int MAX_SAMPLES = 65536;
   localparam int COUNT_W     = 17;
   localparam int Q_W         = 48;
   localparam int SUM_W       = 64;
   localparam int DIVD_W      = 81;
   localparam int DIV_CNT_W   = 7;
   localparam int SHIFT_W     = 5;

   localparam logic signed [Q_W-1:0] Q48_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [Q_W-1:0] Q48_MIN = 48'sh8000_0000_0000;

   // dV/dQ scale is 720000 * 2^16
   localparam logic signed [20:0] RATIO_K = 21'sd720000;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_SHORT    = 2'd1;
   localparam logic [1:0] STATUS_DIV_ZERO = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_UPDATE,
      ST_MULT,
      ST_CHARGE,
      ST_DIV_GO,
      ST_DIV_WAIT,
      ST_COMMIT,
      ST_OUT
   } bdfe_state_type;

   typedef enum logic [3:0] {
      OP_RATE_V,
      OP_RATE_T,
      OP_RATIO_A,
      OP_RATIO_B,
      OP_F0,
      OP_F1,
      OP_F2,
      OP_F3,
      OP_F4,
      OP_F5,
      OP_F8,
      OP_F9
   } bdfe_op_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_PREP,
      DIV_RUN,
      DIV_FIX
   } bdfe_div_state_type;

   typedef struct packed {
      logic                      start;
      logic signed [SUM_W-1:0]   num;
      logic signed [SUM_W-1:0]   den;
      logic [SHIFT_W-1:0]        shift;
   } bdfe_div_req_type;

   typedef struct packed {
      logic                    done;
      logic                    zero_div;
      logic signed [Q_W-1:0]   quot;
   } bdfe_div_rsp_type;

endpackage

[rtl/bdfe_if.sv]
// Interfaces: sample word channel and feature word channel.
`timescale 1ns / 1ps
interface bdfe_req_if;
   logic               valid;
   logic               ready;
   logic [15:0]        voltage_sample;
   logic signed [15:0] current_sample;
   logic signed [15:0] temperature_sample;
   logic [31:0]        time_stamp;
   logic               last_sample;

   modport source (output valid, voltage_sample, current_sample, temperature_sample,
                   time_stamp, last_sample, input ready);
   modport sink (input valid, voltage_sample, current_sample, temperature_sample,
                 time_stamp, last_sample, output ready);
endinterface

interface bdfe_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [47:0] voltage_rate_mean;
   logic signed [47:0] voltage_mean;
   logic signed [47:0] temperature_rate_mean;
   logic signed [47:0] power_mean;
   logic signed [47:0] relative_time_mean;
   logic signed [47:0] slope_ratio_mean;
   logic signed [47:0] slope_ratio_max;
   logic signed [47:0] slope_ratio_min;
   logic signed [47:0] record_duration;
   logic signed [47:0] temperature_mean;
   logic [1:0]         record_status;

   modport source (output valid, voltage_rate_mean, voltage_mean, temperature_rate_mean,
                   power_mean, relative_time_mean, slope_ratio_mean, slope_ratio_max,
                   slope_ratio_min, record_duration, temperature_mean, record_status,
                   input ready);
   modport sink (input valid, voltage_rate_mean, voltage_mean, temperature_rate_mean,
                 power_mean, relative_time_mean, slope_ratio_mean, slope_ratio_max,
                 slope_ratio_min, record_duration, temperature_mean, record_status,
                 output ready);
endinterface

[rtl/bdfe_div.sv]
// Shared radix-2 divider: round(num * 2^shift / den), nearest, saturated to 48 bits.
`timescale 1ns / 1ps
module bdfe_div (
   input  logic                        clock,
   input  logic                        reset,
   input  bdfe_pkg::bdfe_div_req_type  div_req,
   output bdfe_pkg::bdfe_div_rsp_type  div_rsp
);

   bdfe_pkg::bdfe_div_state_type state_ff, state_in;

   logic [bdfe_pkg::SUM_W-1:0]     un_ff, ud_ff;
   logic                           neg_ff;
   logic [bdfe_pkg::SHIFT_W-1:0]   sh_ff;
   logic [bdfe_pkg::DIVD_W-1:0]    dvd_ff;
   logic [bdfe_pkg::SUM_W-1:0]     rem_ff;
   logic [bdfe_pkg::DIV_CNT_W-1:0] cnt_ff;
   logic                           done_ff;
   logic                           dz_ff;
   logic signed [bdfe_pkg::Q_W-1:0] quot_ff;

   logic [bdfe_pkg::SUM_W-1:0]   num_mag, den_mag;
   logic                         den_zero;
   logic [bdfe_pkg::SUM_W:0]     rem_sh;
   logic                         ge;
   logic [bdfe_pkg::SUM_W-1:0]   rem_next;
   logic [bdfe_pkg::DIVD_W-1:0]  dvd_prep;
   logic [bdfe_pkg::Q_W-1:0]     lim, mag, qres;
   logic                         sat;

   always_comb begin
      num_mag  = div_req.num[bdfe_pkg::SUM_W-1] ? (~div_req.num + 64'd1) : div_req.num;
      den_mag  = div_req.den[bdfe_pkg::SUM_W-1] ? (~div_req.den + 64'd1) : div_req.den;
      den_zero = (div_req.den == '0);
      // numerator shifted up plus half the divisor gives round-half-up of magnitude
      dvd_prep = ({17'b0, un_ff} << sh_ff) + {18'b0, ud_ff[bdfe_pkg::SUM_W-1:1]};
      rem_sh   = {rem_ff, dvd_ff[bdfe_pkg::DIVD_W-1]};
      ge       = (rem_sh >= {1'b0, ud_ff});
      rem_next = ge ? 64'(rem_sh - {1'b0, ud_ff}) : rem_sh[bdfe_pkg::SUM_W-1:0];
      lim      = neg_ff ? 48'h8000_0000_0000 : 48'h7FFF_FFFF_FFFF;
      sat      = (|dvd_ff[bdfe_pkg::DIVD_W-1:bdfe_pkg::Q_W]) ||
                 (dvd_ff[bdfe_pkg::Q_W-1:0] > lim);
      mag      = sat ? lim : dvd_ff[bdfe_pkg::Q_W-1:0];
      qres     = neg_ff ? (~mag + 48'd1) : mag;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bdfe_pkg::DIV_IDLE: begin
            if (div_req.start && !den_zero) state_in = bdfe_pkg::DIV_PREP;
         end
         bdfe_pkg::DIV_PREP: state_in = bdfe_pkg::DIV_RUN;
         bdfe_pkg::DIV_RUN: begin
            if (cnt_ff == '0) state_in = bdfe_pkg::DIV_FIX;
         end
         bdfe_pkg::DIV_FIX: state_in = bdfe_pkg::DIV_IDLE;
         default: state_in = bdfe_pkg::DIV_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      div_rsp.done     = done_ff;
      div_rsp.zero_div = dz_ff;
      div_rsp.quot     = quot_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bdfe_pkg::DIV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= (state_ff == bdfe_pkg::DIV_FIX) ||
                     (state_ff == bdfe_pkg::DIV_IDLE && div_req.start && den_zero);
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         bdfe_pkg::DIV_IDLE: begin
            if (div_req.start) begin
               un_ff  <= num_mag;
               ud_ff  <= den_mag;
               neg_ff <= div_req.num[bdfe_pkg::SUM_W-1] ^ div_req.den[bdfe_pkg::SUM_W-1];
               sh_ff  <= div_req.shift;
               dz_ff  <= den_zero;
               if (den_zero) begin
                  if (div_req.num > 0)      quot_ff <= bdfe_pkg::Q48_MAX;
                  else if (div_req.num < 0) quot_ff <= bdfe_pkg::Q48_MIN;
                  else                      quot_ff <= '0;
               end
            end
         end
         bdfe_pkg::DIV_PREP: begin
            dvd_ff <= dvd_prep;
            rem_ff <= '0;
            cnt_ff <= 7'(bdfe_pkg::DIVD_W - 1);
         end
         bdfe_pkg::DIV_RUN: begin
            dvd_ff <= {dvd_ff[bdfe_pkg::DIVD_W-2:0], ge};
            rem_ff <= rem_next;
            cnt_ff <= cnt_ff - 7'd1;
         end
         bdfe_pkg::DIV_FIX: begin
            quot_ff <= $signed(qres);
            dz_ff   <= 1'b0;
         end
         default: ;
      endcase
   end

endmodule

[rtl/battery_discharge_feature_extractor_core.sv]
// Top level: discharge record feature extractor with a shared divider.
`timescale 1ns / 1ps
`include "battery_discharge_feature_extractor_core_defines.svh"
// Usage:
//  req_chan takes one sample word (voltage, current, temperature, time stamp,
//  last flag) per valid/ready handshake. rsp_chan gives one feature word per
//  record: ten Q32.16 features and a status, after the record's last sample.
//  ready on req_chan is high only while the sequencer is idle; one word is
//  worked on at a time.
//  Each divide runs on the one radix-2 divider, 81 steps plus setup and
//  rounding; a zero divisor skips them and returns a saturated quotient.
//  Work per sample: no divide for the first sample, two rate divides for the
//  second, two rate divides and one dV/dQ divide for later ones, plus one
//  closing ratio divide on a last sample, then the eight closing feature
//  divides for a record of three samples or more.
//  Reset clears every sum, window and the sample count; the divider returns
//  to idle. The result sits in an output register: a stalled receiver does
//  not stop intake until the next record closes, and then intake waits for it.
//  A record reaching 65536 samples closes as if flagged last.
module battery_discharge_feature_extractor_core (
   input  logic       clock,
   input  logic       reset,
   bdfe_req_if.sink   req_chan,
   bdfe_rsp_if.source rsp_chan
);

   function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
                                                    input logic signed [63:0] b);
      logic signed [64:0] s;
      begin
         s = 65'(a) + 65'(b);
         if (s[64] != s[63]) sat_add64 = s[64] ? 64'sh8000_0000_0000_0000
                                                : 64'sh7FFF_FFFF_FFFF_FFFF;
         else                sat_add64 = s[63:0];
      end
   endfunction

   function automatic logic signed [47:0] sat48(input logic signed [50:0] x);
      begin
         if (x[50:47] != {4{x[50]}}) sat48 = x[50] ? bdfe_pkg::Q48_MIN : bdfe_pkg::Q48_MAX;
         else                         sat48 = x[47:0];
      end
   endfunction

   bdfe_pkg::bdfe_state_type state_ff, state_in;
   bdfe_pkg::bdfe_op_type    op_ff, op_in;

   // latched sample word
   logic [15:0]        v_ff;
   logic signed [15:0] cur_ff, tmp_ff;
   logic [31:0]        tm_ff;
   logic               last_ff;

   // record state
   logic [bdfe_pkg::COUNT_W-1:0] count_ff;
   logic [31:0]                  start_ff, prev_time_ff;
   logic [15:0]                  pv0_ff, pv1_ff;
   logic signed [15:0]           pcur_ff, ptmp_ff;
   logic signed [47:0]           cw_ff [0:2];
   logic signed [17:0]           pend_ff [0:1];
   logic signed [63:0]           sum_ff [0:6];
   logic signed [47:0]           rmax_ff, rmin_ff;
   logic                         fault_ff;

   // working registers
   logic signed [32:0] dt_ff, rel_ff;
   logic signed [49:0] prod_ff;
   logic signed [47:0] feat_ff [0:7];

   // result register
   logic               rsp_valid_ff;
   logic signed [47:0] res_ff [0:9];
   logic [1:0]         status_ff;

   logic req_ready, load_out, req_fire, short_rec;

   logic signed [32:0] rel_now, dt_now, vc;
   logic signed [16:0] csum;
   logic signed [17:0] dv0, dv1, g;
   logic signed [48:0] d01, d02;
   logic signed [49:0] end_dq;
   logic signed [38:0] ratio_num;
   logic signed [63:0] n64;

   bdfe_pkg::bdfe_div_req_type div_req;
   bdfe_pkg::bdfe_div_rsp_type div_rsp;

   bdfe_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   always_comb begin
      req_fire  = req_chan.valid && req_ready;
      short_rec = (count_ff < 17'd3);
      rel_now   = (count_ff == '0) ? 33'sd0
                : $signed({1'b0, tm_ff}) - $signed({1'b0, start_ff});
      dt_now    = $signed({1'b0, tm_ff}) - $signed({1'b0, prev_time_ff});
      vc        = 33'($signed({1'b0, v_ff})) * 33'(cur_ff);
      csum      = 17'(pcur_ff) + 17'(cur_ff);
      dv0       = 18'($signed({1'b0, v_ff})) - 18'($signed({1'b0, pv0_ff}));
      dv1       = 18'($signed({1'b0, v_ff})) - 18'($signed({1'b0, pv1_ff}));
      g         = (count_ff == 17'd1) ? (dv0 <<< 1) : dv1;
      d01       = 49'(cw_ff[0]) - 49'(cw_ff[1]);
      d02       = 49'(cw_ff[0]) - 49'(cw_ff[2]);
      end_dq    = 50'(d01) <<< 1;
      ratio_num = 39'((op_ff == bdfe_pkg::OP_RATIO_B) ? pend_ff[0] : pend_ff[1])
                * 39'(bdfe_pkg::RATIO_K);
      n64       = $signed(64'(count_ff));
   end

   // divider request per operation
   always_comb begin
      div_req       = '0;
      div_req.start = (state_ff == bdfe_pkg::ST_DIV_GO);
      case (op_ff)
         bdfe_pkg::OP_RATE_V: begin
            div_req.num   = 64'(dv0);
            div_req.den   = 64'(dt_ff) * 64'sd10;
            div_req.shift = 5'd16;
         end
         bdfe_pkg::OP_RATE_T: begin
            div_req.num   = 64'(18'(tmp_ff) - 18'(ptmp_ff)) * 64'sd10;
            div_req.den   = 64'(dt_ff);
            div_req.shift = 5'd16;
         end
         bdfe_pkg::OP_RATIO_A: begin
            div_req.num   = 64'(ratio_num);
            div_req.den   = (count_ff == 17'd2) ? 64'(end_dq) : 64'(d02);
            div_req.shift = 5'd16;
         end
         bdfe_pkg::OP_RATIO_B: begin
            div_req.num   = 64'(ratio_num);
            div_req.den   = 64'(end_dq);
            div_req.shift = 5'd16;
         end
         bdfe_pkg::OP_F0: begin
            div_req.num = sum_ff[0];
            div_req.den = n64 - 64'sd1;
         end
         bdfe_pkg::OP_F1: begin
            div_req.num   = sum_ff[1];
            div_req.den   = n64 * 64'sd10000;
            div_req.shift = 5'd16;
         end
         bdfe_pkg::OP_F2: begin
            div_req.num = sum_ff[2];
            div_req.den = n64 - 64'sd1;
         end
         bdfe_pkg::OP_F3: begin
            div_req.num   = sum_ff[3];
            div_req.den   = n64 * 64'sd625000;
            div_req.shift = 5'd12;
         end
         bdfe_pkg::OP_F4: begin
            div_req.num   = sum_ff[4];
            div_req.den   = n64 * 64'sd125;
            div_req.shift = 5'd13;
         end
         bdfe_pkg::OP_F5: begin
            div_req.num = sum_ff[5];
            div_req.den = n64 - 64'sd1;
         end
         bdfe_pkg::OP_F8: begin
            div_req.num   = 64'(rel_ff);
            div_req.den   = 64'sd125;
            div_req.shift = 5'd13;
         end
         bdfe_pkg::OP_F9: begin
            div_req.num   = sum_ff[6];
            div_req.den   = n64 * 64'sd25;
            div_req.shift = 5'd14;
         end
         default: ;
      endcase
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      case (state_ff)
         bdfe_pkg::ST_IDLE: begin
            if (req_fire) state_in = bdfe_pkg::ST_UPDATE;
         end
         bdfe_pkg::ST_UPDATE: begin
            state_in = (count_ff == '0) ? bdfe_pkg::ST_COMMIT : bdfe_pkg::ST_MULT;
         end
         bdfe_pkg::ST_MULT: state_in = bdfe_pkg::ST_CHARGE;
         bdfe_pkg::ST_CHARGE: begin
            state_in = bdfe_pkg::ST_DIV_GO;
            op_in    = bdfe_pkg::OP_RATE_V;
         end
         bdfe_pkg::ST_DIV_GO: state_in = bdfe_pkg::ST_DIV_WAIT;
         bdfe_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               state_in = bdfe_pkg::ST_DIV_GO;
               case (op_ff)
                  bdfe_pkg::OP_RATE_V: op_in = bdfe_pkg::OP_RATE_T;
                  bdfe_pkg::OP_RATE_T: begin
                     if (count_ff >= 17'd2) op_in = bdfe_pkg::OP_RATIO_A;
                     else                   state_in = bdfe_pkg::ST_COMMIT;
                  end
                  bdfe_pkg::OP_RATIO_A: begin
                     if (last_ff) op_in = bdfe_pkg::OP_RATIO_B;
                     else         state_in = bdfe_pkg::ST_COMMIT;
                  end
                  bdfe_pkg::OP_RATIO_B: state_in = bdfe_pkg::ST_COMMIT;
                  bdfe_pkg::OP_F0: op_in = bdfe_pkg::OP_F1;
                  bdfe_pkg::OP_F1: op_in = bdfe_pkg::OP_F2;
                  bdfe_pkg::OP_F2: op_in = bdfe_pkg::OP_F3;
                  bdfe_pkg::OP_F3: op_in = bdfe_pkg::OP_F4;
                  bdfe_pkg::OP_F4: op_in = bdfe_pkg::OP_F5;
                  bdfe_pkg::OP_F5: op_in = bdfe_pkg::OP_F8;
                  bdfe_pkg::OP_F8: op_in = bdfe_pkg::OP_F9;
                  bdfe_pkg::OP_F9: state_in = bdfe_pkg::ST_OUT;
                  default: state_in = bdfe_pkg::ST_IDLE;
               endcase
            end
         end
         bdfe_pkg::ST_COMMIT: begin
            if (!last_ff) begin
               state_in = bdfe_pkg::ST_IDLE;
            end else if (count_ff < 17'd2) begin
               state_in = bdfe_pkg::ST_OUT;
            end else begin
               state_in = bdfe_pkg::ST_DIV_GO;
               op_in    = bdfe_pkg::OP_F0;
            end
         end
         bdfe_pkg::ST_OUT: begin
            if (load_out) state_in = bdfe_pkg::ST_IDLE;
         end
         default: state_in = bdfe_pkg::ST_IDLE;
      endcase
   end

   // sequencer outputs
   always_comb begin
      req_ready = (state_ff == bdfe_pkg::ST_IDLE);
      load_out  = (state_ff == bdfe_pkg::ST_OUT) && (!rsp_valid_ff || rsp_chan.ready);
   end

   assign req_chan.ready = req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bdfe_pkg::ST_IDLE;
         op_ff        <= bdfe_pkg::OP_RATE_V;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         op_ff    <= op_in;
         if (load_out)            rsp_valid_ff <= 1'b1;
         else if (rsp_chan.ready) rsp_valid_ff <= 1'b0;
      end
   end

   // sample word latch
   always_ff @(posedge clock) begin
      if (req_fire) begin
         v_ff    <= req_chan.voltage_sample;
         cur_ff  <= req_chan.current_sample;
         tmp_ff  <= req_chan.temperature_sample;
         tm_ff   <= req_chan.time_stamp;
         last_ff <= req_chan.last_sample ||
                    (count_ff >= 17'(bdfe_pkg::MAX_SAMPLES - 1));
      end
   end

   // record state, cleared at reset and when a result is handed over
   always_ff @(posedge clock) begin
      if (reset || load_out) begin
         count_ff     <= '0;
         start_ff     <= '0;
         prev_time_ff <= '0;
         pv0_ff       <= '0;
         pv1_ff       <= '0;
         pcur_ff      <= '0;
         ptmp_ff      <= '0;
         for (int i = 0; i < 3; i++) cw_ff[i] <= '0;
         pend_ff[0]   <= '0;
         pend_ff[1]   <= '0;
         for (int i = 0; i < 7; i++) sum_ff[i] <= '0;
         rmax_ff      <= bdfe_pkg::Q48_MIN;
         rmin_ff      <= bdfe_pkg::Q48_MAX;
         fault_ff     <= 1'b0;
      end else begin
         case (state_ff)
            bdfe_pkg::ST_UPDATE: begin
               if (count_ff == '0) start_ff <= tm_ff;
               sum_ff[1] <= sat_add64(sum_ff[1], 64'($signed({1'b0, v_ff})));
               sum_ff[3] <= sat_add64(sum_ff[3], 64'(vc));
               sum_ff[4] <= sat_add64(sum_ff[4], 64'(rel_now));
               sum_ff[6] <= sat_add64(sum_ff[6], 64'(tmp_ff));
            end
            bdfe_pkg::ST_CHARGE: begin
               // negated trapezoid charge, window shifts by one
               cw_ff[2]   <= cw_ff[1];
               cw_ff[1]   <= cw_ff[0];
               cw_ff[0]   <= sat48(51'(cw_ff[0]) - 51'(prod_ff));
               pend_ff[1] <= pend_ff[0];
               pend_ff[0] <= g;
            end
            bdfe_pkg::ST_DIV_WAIT: begin
               if (div_rsp.done) begin
                  fault_ff <= fault_ff | div_rsp.zero_div;
                  case (op_ff)
                     bdfe_pkg::OP_RATE_V: sum_ff[0] <= sat_add64(sum_ff[0], 64'(div_rsp.quot));
                     bdfe_pkg::OP_RATE_T: sum_ff[2] <= sat_add64(sum_ff[2], 64'(div_rsp.quot));
                     bdfe_pkg::OP_RATIO_A, bdfe_pkg::OP_RATIO_B: begin
                        sum_ff[5] <= sat_add64(sum_ff[5], 64'(div_rsp.quot));
                        if (div_rsp.quot > rmax_ff) rmax_ff <= div_rsp.quot;
                        if (div_rsp.quot < rmin_ff) rmin_ff <= div_rsp.quot;
                     end
                     default: ;
                  endcase
               end
            end
            bdfe_pkg::ST_COMMIT: begin
               pv1_ff       <= pv0_ff;
               pv0_ff       <= v_ff;
               pcur_ff      <= cur_ff;
               ptmp_ff      <= tmp_ff;
               prev_time_ff <= tm_ff;
               count_ff     <= count_ff + 17'd1;
            end
            default: ;
         endcase
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      case (state_ff)
         bdfe_pkg::ST_UPDATE: begin
            rel_ff <= rel_now;
            dt_ff  <= dt_now;
         end
         bdfe_pkg::ST_MULT: prod_ff <= 50'(csum) * 50'(dt_ff);
         bdfe_pkg::ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               case (op_ff)
                  bdfe_pkg::OP_F0: feat_ff[0] <= div_rsp.quot;
                  bdfe_pkg::OP_F1: feat_ff[1] <= div_rsp.quot;
                  bdfe_pkg::OP_F2: feat_ff[2] <= div_rsp.quot;
                  bdfe_pkg::OP_F3: feat_ff[3] <= div_rsp.quot;
                  bdfe_pkg::OP_F4: feat_ff[4] <= div_rsp.quot;
                  bdfe_pkg::OP_F5: feat_ff[5] <= div_rsp.quot;
                  bdfe_pkg::OP_F8: feat_ff[6] <= div_rsp.quot;
                  bdfe_pkg::OP_F9: feat_ff[7] <= div_rsp.quot;
                  default: ;
               endcase
            end
         end
         default: ;
      endcase
   end

   // result register; a short record reports zeros
   always_ff @(posedge clock) begin
      if (load_out) begin
         res_ff[0] <= short_rec ? '0 : feat_ff[0];
         res_ff[1] <= short_rec ? '0 : feat_ff[1];
         res_ff[2] <= short_rec ? '0 : feat_ff[2];
         res_ff[3] <= short_rec ? '0 : feat_ff[3];
         res_ff[4] <= short_rec ? '0 : feat_ff[4];
         res_ff[5] <= short_rec ? '0 : feat_ff[5];
         res_ff[6] <= short_rec ? '0 : rmax_ff;
         res_ff[7] <= short_rec ? '0 : rmin_ff;
         res_ff[8] <= short_rec ? '0 : feat_ff[6];
         res_ff[9] <= short_rec ? '0 : feat_ff[7];
         status_ff <= short_rec ? bdfe_pkg::STATUS_SHORT
                    : (fault_ff ? bdfe_pkg::STATUS_DIV_ZERO : bdfe_pkg::STATUS_OK);
      end
   end

   assign rsp_chan.valid                 = rsp_valid_ff;
   assign rsp_chan.voltage_rate_mean     = res_ff[0];
   assign rsp_chan.voltage_mean          = res_ff[1];
   assign rsp_chan.temperature_rate_mean = res_ff[2];
   assign rsp_chan.power_mean            = res_ff[3];
   assign rsp_chan.relative_time_mean    = res_ff[4];
   assign rsp_chan.slope_ratio_mean      = res_ff[5];
   assign rsp_chan.slope_ratio_max       = res_ff[6];
   assign rsp_chan.slope_ratio_min       = res_ff[7];
   assign rsp_chan.record_duration       = res_ff[8];
   assign rsp_chan.temperature_mean      = res_ff[9];
   assign rsp_chan.record_status         = status_ff;

   `BDFE_ASSERT_NEXT(a_accept_starts, clock, reset, req_fire, state_ff == bdfe_pkg::ST_UPDATE)
   `BDFE_ASSERT_IMPL(a_div_done_waited, clock, reset, div_rsp.done, state_ff == bdfe_pkg::ST_DIV_WAIT)
   `BDFE_ASSERT_IMPL(a_rsp_from_out, clock, reset, $rose(rsp_valid_ff), $past(state_ff) == bdfe_pkg::ST_OUT)

endmodule

[dv/tb_top.sv]
// Testbench for the discharge feature extractor: random records, feature prediction, scoreboard.
`timescale 1ns / 1ps
module tb_top;

   localparam longint Q_HI        = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint Q_LO        = -Q_HI - 1;
   localparam longint DVDQ_SCALE  = 64'sd47185920000;
   localparam int     ITEM_TARGET = 950;
   localparam int     HOLD_CYCLES = 25000;

   typedef struct {
      logic [15:0]        volt;
      logic signed [15:0] curr;
      logic signed [15:0] temp;
      logic [31:0]        stamp;
      logic               last;
   } sample_type;

   typedef struct {
      longint     feat[10];
      logic [1:0] status;
   } features_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bdfe_req_if req_chan ();
   bdfe_rsp_if rsp_chan ();

   battery_discharge_feature_extractor_core DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   sample_type   sample_q[$];
   features_type feature_q[$];
   sample_type   on_bus;
   int           n_sent = 0;
   int           n_recs = 0;
   int           n_fail = 0;

   // ---------------- predictor state ----------------
   int unsigned  cnt;
   logic [31:0]  t_start, t_prev;
   longint       v_prev[2];
   longint       i_prev, tc_prev;
   longint       qwin[3];
   longint       grad[2];
   longint       acc[7];
   longint       r_max, r_min;
   bit           div_flag;

   function automatic void clear_record();
      cnt = 0; t_start = 0; t_prev = 0;
      v_prev = '{0, 0}; i_prev = 0; tc_prev = 0;
      qwin = '{0, 0, 0}; grad = '{0, 0};
      foreach (acc[k]) acc[k] = 0;
      r_max = Q_LO; r_min = Q_HI; div_flag = 0;
   endfunction

   function automatic longint sat_sum(longint a, longint b);
      if (b > 0 && a > 64'sh7FFF_FFFF_FFFF_FFFF - b) return 64'sh7FFF_FFFF_FFFF_FFFF;
      if (b < 0 && a < -64'sh7FFF_FFFF_FFFF_FFFF - 1 - b) return -64'sh7FFF_FFFF_FFFF_FFFF - 1;
      return a + b;
   endfunction

   // round(num*mul/den) to nearest, ties away from zero, clamped to 48 bits
   function automatic longint round_div(longint num, longint unsigned mul, longint den);
      bit neg;
      longint unsigned un, ud, lim, q, r, res, frac;
      if (den == 0) begin
         div_flag = 1;
         return (num > 0) ? Q_HI : ((num < 0) ? Q_LO : 0);
      end
      un  = (num < 0) ? 64'd0 - num : num;
      ud  = (den < 0) ? 64'd0 - den : den;
      neg = (num < 0) != (den < 0);
      lim = neg ? 64'd1 << 47 : (64'd1 << 47) - 1;
      q = un / ud;
      r = un % ud;
      if (q > lim / mul) return neg ? Q_LO : Q_HI;
      res  = q * mul;
      frac = (r * mul + ud / 2) / ud;
      if (frac > lim - res) return neg ? Q_LO : Q_HI;
      res += frac;
      return neg ? -longint'(res) : longint'(res);
   endfunction

   function automatic void fold_slope(longint dv2, longint dq2);
      longint r;
      r = round_div(dv2 * DVDQ_SCALE, 1, dq2);
      acc[5] = sat_sum(acc[5], r);
      if (r > r_max) r_max = r;
      if (r < r_min) r_min = r;
   endfunction

   function automatic longint clamp48(longint x);
      if (x > Q_HI) return Q_HI;
      if (x < Q_LO) return Q_LO;
      return x;
   endfunction

   // advance the record by one sample; returns 1 when a feature word is due
   function automatic bit predict_sample(sample_type s, output features_type fw);
      longint v, c, tc, rel, dt, g, dq_end, n;
      int unsigned k;
      bit closing;
      v  = longint'(s.volt);
      c  = longint'(s.curr);
      tc = longint'(s.temp);
      k  = cnt;
      closing = s.last || (k >= bdfe_pkg::MAX_SAMPLES - 1);
      if (k == 0) t_start = s.stamp;
      rel = longint'(s.stamp) - longint'(t_start);
      acc[1] = sat_sum(acc[1], v);
      acc[3] = sat_sum(acc[3], v * c);
      acc[4] = sat_sum(acc[4], rel);
      acc[6] = sat_sum(acc[6], tc);
      if (k > 0) begin
         dt = longint'(s.stamp) - longint'(t_prev);
         acc[0] = sat_sum(acc[0], round_div(v - v_prev[0], 65536, 10 * dt));
         acc[2] = sat_sum(acc[2], round_div(10 * (tc - tc_prev), 65536, dt));
         qwin[2] = qwin[1];
         qwin[1] = qwin[0];
         qwin[0] = clamp48(qwin[1] - (i_prev + c) * dt);
         // one-sided at the first point, central after that
         g = (k == 1) ? 2 * (v - v_prev[0]) : v - v_prev[1];
         grad[1] = grad[0];
         grad[0] = g;
         if (k >= 2) begin
            dq_end = 2 * (qwin[0] - qwin[1]);
            fold_slope(grad[1], (k == 2) ? dq_end : qwin[0] - qwin[2]);
            if (closing) fold_slope(grad[0], dq_end);
         end
      end
      v_prev[1] = v_prev[0];
      v_prev[0] = v;
      i_prev  = c;
      tc_prev = tc;
      t_prev  = s.stamp;
      cnt = k + 1;
      if (!closing) return 0;
      n = longint'(k) + 1;
      if (n < 3) begin
         foreach (fw.feat[j]) fw.feat[j] = 0;
         fw.status = bdfe_pkg::STATUS_SHORT;
      end else begin
         fw.feat[0] = round_div(acc[0], 1, n - 1);
         fw.feat[1] = round_div(acc[1], 65536, 10000 * n);
         fw.feat[2] = round_div(acc[2], 1, n - 1);
         fw.feat[3] = round_div(acc[3], 4096, 625000 * n);
         fw.feat[4] = round_div(acc[4], 8192, 125 * n);
         fw.feat[5] = round_div(acc[5], 1, n - 1);
         fw.feat[6] = r_max;
         fw.feat[7] = r_min;
         fw.feat[8] = round_div(rel, 8192, 125);
         fw.feat[9] = round_div(acc[6], 16384, 25 * n);
         fw.status = div_flag ? bdfe_pkg::STATUS_DIV_ZERO : bdfe_pkg::STATUS_OK;
      end
      clear_record();
      return 1;
   endfunction

   // ---------------- stimulus ----------------
   function automatic void push_word(logic [15:0] v, logic [15:0] c, logic [15:0] t,
                                     logic [31:0] ts, logic l);
      sample_type s;
      s.volt = v; s.curr = c; s.temp = t; s.stamp = ts; s.last = l;
      sample_q.push_back(s);
   endfunction

   // mode 0: plausible discharge, 1: stalls and backward steps, 2: anything goes
   function automatic void push_record(int len, int mode);
      logic [31:0] ts;
      logic [15:0] v;
      ts = $urandom;
      v  = 16'($urandom_range(42000, 30000));
      for (int j = 0; j < len; j++) begin
         case (mode)
            0: begin
               push_word(v, 16'(-$urandom_range(20000, 0)),
                         16'($urandom_range(4500, 1500)), ts, j == len - 1);
               ts += $urandom_range(5000, 1);
               v  = 16'(v - 16'($urandom_range(60, 0)));
            end
            1: begin
               push_word(v, 16'($urandom), 16'($urandom), ts, j == len - 1);
               case ($urandom_range(3))
                  0: ts += 0;
                  1: ts -= $urandom_range(3000);
                  default: ts += $urandom_range(100000);
               endcase
               v = 16'(v + 16'($urandom_range(400)) - 16'd200);
            end
            default: push_word(16'($urandom), 16'($urandom), 16'($urandom), $urandom,
                               j == len - 1);
         endcase
         n_sent++;
      end
   endfunction

   initial begin
      int len;
      // short records: one and two samples
      push_word(16'hFFFF, 16'h8000, 16'h7FFF, 32'hFFFF_FFFF, 1'b1);
      push_word(16'h0000, 16'h7FFF, 16'h8000, 32'h0000_0000, 1'b0);
      push_word(16'hFFFF, 16'h8000, 16'h7FFF, 32'h0000_03E8, 1'b1);
      // three samples, repeated stamp gives zero divisors
      push_word(16'd40000, -16'sd1000, 16'sd2500, 32'd5000, 1'b0);
      push_word(16'd39990, -16'sd1000, 16'sd2510, 32'd5000, 1'b0);
      push_word(16'd39980, -16'sd1000, 16'sd2520, 32'd6000, 1'b1);
      // zero current: charge never moves
      push_word(16'd41000, 16'sd0, 16'sd0, 32'd0, 1'b0);
      push_word(16'd40900, 16'sd0, 16'sd0, 32'd10, 1'b0);
      push_word(16'd40800, 16'sd0, 16'sd0, 32'd20, 1'b0);
      push_word(16'd40700, 16'sd0, 16'sd0, 32'd30, 1'b1);
      // extremes, stamps wrapping and running backwards
      push_word(16'hFFFF, 16'h7FFF, 16'h7FFF, 32'hFFFF_FFF0, 1'b0);
      push_word(16'h0000, 16'h8000, 16'h8000, 32'h0000_0010, 1'b0);
      push_word(16'hFFFF, 16'h7FFF, 16'h7FFF, 32'h0000_0008, 1'b0);
      push_word(16'h0000, 16'h8000, 16'h8000, 32'h8000_0000, 1'b1);
      // ordinary discharge
      push_word(16'd41000, -16'sd2000, 16'sd2500, 32'd100, 1'b0);
      push_word(16'd40950, -16'sd2000, 16'sd2501, 32'd1100, 1'b0);
      push_word(16'd40890, -16'sd2000, 16'sd2503, 32'd2100, 1'b0);
      push_word(16'd40820, -16'sd2000, 16'sd2506, 32'd3100, 1'b0);
      push_word(16'd40740, -16'sd2000, 16'sd2510, 32'd4100, 1'b1);
      n_sent = sample_q.size();
      while (n_sent < ITEM_TARGET) begin
         len = ($urandom_range(9) == 0) ? $urandom_range(2, 1) : $urandom_range(14, 3);
         case ($urandom_range(9))
            0, 1:    push_record(len, 1);
            2:       push_record(len, 2);
            default: push_record(len, 0);
         endcase
      end
   end

   // ---------------- driver ----------------
   always @(posedge clock) begin
      features_type fw;
      if (reset) begin
         clear_record();
         req_chan.valid              <= 1'b0;
         req_chan.voltage_sample     <= '0;
         req_chan.current_sample     <= '0;
         req_chan.temperature_sample <= '0;
         req_chan.time_stamp         <= '0;
         req_chan.last_sample        <= 1'b0;
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            if (predict_sample(on_bus, fw)) feature_q.push_back(fw);
         end
         if ((!req_chan.valid || req_chan.ready) && sample_q.size() > 0 &&
             ((n_recs >= 40 && n_recs < 70) || $urandom_range(99) >= 15)) begin
            on_bus = sample_q.pop_front();
            req_chan.voltage_sample     <= on_bus.volt;
            req_chan.current_sample     <= on_bus.curr;
            req_chan.temperature_sample <= on_bus.temp;
            req_chan.time_stamp         <= on_bus.stamp;
            req_chan.last_sample        <= on_bus.last;
            req_chan.valid              <= 1'b1;
         end else if (req_chan.ready) begin
            req_chan.valid <= 1'b0;
         end
      end
   end

   // ---------------- receiver stall ----------------
   int hold_left = 0;
   bit hold_done = 0;
   always @(posedge clock) begin
      if (!reset && !hold_done && n_recs == 10) begin
         hold_left <= HOLD_CYCLES;
         hold_done <= 1'b1;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // ---------------- monitor ----------------
   string field_name[10] = '{"voltage_rate_mean", "voltage_mean", "temperature_rate_mean",
                             "power_mean", "relative_time_mean", "slope_ratio_mean",
                             "slope_ratio_max", "slope_ratio_min", "record_duration",
                             "temperature_mean"};

   always @(posedge clock) begin
      features_type exp_w;
      logic [47:0] got[10];
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            n_recs++;
            got = '{rsp_chan.voltage_rate_mean, rsp_chan.voltage_mean,
                    rsp_chan.temperature_rate_mean, rsp_chan.power_mean,
                    rsp_chan.relative_time_mean, rsp_chan.slope_ratio_mean,
                    rsp_chan.slope_ratio_max, rsp_chan.slope_ratio_min,
                    rsp_chan.record_duration, rsp_chan.temperature_mean};
            if (feature_q.size() == 0) begin
               $error("feature word with none expected");
               n_fail++;
            end else begin
               exp_w = feature_q.pop_front();
               for (int j = 0; j < 10; j++) begin
                  if (got[j] !== exp_w.feat[j][47:0]) begin
                     $error("%s: expected %h, got %h", field_name[j],
                            exp_w.feat[j][47:0], got[j]);
                     n_fail++;
                  end
               end
               if (rsp_chan.record_status !== exp_w.status) begin
                  $error("record_status: expected %0d, got %0d",
                         exp_w.status, rsp_chan.record_status);
                  n_fail++;
               end
            end
         end
         rsp_chan.ready <= (hold_left > 1) ? 1'b0 :
                           ((n_recs >= 40 && n_recs < 70) || $urandom_range(99) >= 15);
      end
   end

   // ---------------- end of run ----------------
   initial begin
      @(negedge reset);
      while (sample_q.size() > 0 || req_chan.valid || feature_q.size() > 0)
         @(posedge clock);
      repeat (2000) @(posedge clock);
      if (n_fail == 0 && feature_q.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/bdfe_pkg.sv
rtl/bdfe_if.sv
rtl/bdfe_div.sv
rtl/battery_discharge_feature_extractor_core.sv
dv/tb_top.sv
